>>> src/xbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xbc_pkg;

  // Instruction-length limit and the width of the byte counter.
  localparam int unsigned MaxLength = 16;
  localparam int unsigned PosWidth  = 5;

  localparam logic [7:0] EscapeByte = 8'h0f;

  typedef logic [PosWidth-1:0] pos_t;

  // Bit c of row r: the second byte (r*16 + c) after an escape may run directly.
  localparam logic [15:0] EscapeTable [16] = '{
    16'h034C, 16'h0000, 16'h000F, 16'h0002,
    16'hFFFF, 16'h0000, 16'hCFFF, 16'hC0F0,
    16'h0000, 16'hFFFF, 16'hBB3B, 16'hF8FF,
    16'hFF03, 16'hBB2E, 16'hBB26, 16'h772E
  };

  // Segment, operand-size, lock and rep prefixes.
  function automatic logic is_prefix(input logic [7:0] b);
    logic res;
    res = 1'b0;
    if (b inside {8'h26, 8'h36, 8'h3e, 8'h64, 8'h65, 8'h66, 8'hf0, 8'hf2, 8'hf3}) begin
      res = 1'b1;
    end
    return res;
  endfunction

  // Classification of a first opcode byte by its high nibble.
  function automatic logic classify(input logic [7:0] b);
    logic res;
    res = 1'b0;
    case (b[7:4])
      4'h6: begin
        res = !(b inside {8'h62, 8'h67});
      end
      4'h7: begin
        res = 1'b0;
      end
      4'hc: begin
        res = (b inside {[8'hc2:8'hcb]}) || (b == 8'hcf);
      end
      4'hd: begin
        res = b inside {8'hd4, 8'hd5, 8'hd7};
      end
      4'he: begin
        res = b[2] || (b == 8'hea);
      end
      4'hf: begin
        res = (b == 8'hf5) || (b inside {[8'hf8:8'hfd]});
      end
      default: begin
        res = !(b inside {8'h2e, 8'h9a});
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/xbc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface xbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] insn_byte;
  logic       start_req;

  modport source (output valid, output insn_byte, output start_req, input ready);
  modport sink (input valid, input insn_byte, input start_req, output ready);
endinterface

`default_nettype wire

>>> src/xbc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface xbc_out_if;
  logic       valid;
  logic       ready;
  logic       boostable;
  logic [4:0] bytes_examined;

  modport source (output valid, output boostable, output bytes_examined, input ready);
  modport sink (input valid, input boostable, input bytes_examined, output ready);
endinterface

`default_nettype wire

>>> src/x86_boostable_opcode_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Classifies one x86 instruction, fed one byte per request, as boostable or not.
// A request with start_req set begins a new instruction; prefixes and a 0x0f
// escape produce no result unless the length limit is reached, and the deciding
// byte produces exactly one result with the number of bytes examined. Requests
// after the decision are consumed silently until the next start. The block takes
// one byte every cycle while no held result is stalled by out_o.ready; a deciding
// byte passes through the input register and then the result register. While a
// result is held, the byte in the input register waits, and no further byte is
// taken until the result has been taken.
module x86_boostable_opcode_classifier_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xbc_in_if.sink    in_i,
  xbc_out_if.source out_o
);
  import xbc_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;

  // Classification state.
  pos_t pos_q, pos_d;
  logic esc_q, esc_d;
  logic done_q, done_d;

  // Result register.
  logic       out_valid_q;
  logic       ok_q;
  pos_t       count_q;

  logic advance;
  logic emit;
  logic ok_d;
  pos_t cur_pos;
  pos_t base_pos;
  logic base_esc;
  logic base_done;
  logic at_limit;

  // The held byte moves on when the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Per-byte classification.
  always_comb begin
    base_pos  = start_q ? '0 : pos_q;
    base_esc  = start_q ? 1'b0 : esc_q;
    base_done = start_q ? 1'b0 : done_q;
    cur_pos   = (base_pos >= pos_t'(MaxLength)) ? pos_t'(MaxLength) : base_pos + pos_t'(1);
    at_limit  = cur_pos >= pos_t'(MaxLength);
    emit      = 1'b0;
    ok_d      = 1'b0;
    pos_d     = base_pos;
    esc_d     = base_esc;
    done_d    = base_done;
    if (!base_done) begin
      pos_d = cur_pos;
      if (base_esc) begin
        emit = 1'b1;
        ok_d = EscapeTable[byte_q[7:4]][byte_q[3:0]];
      end else if (byte_q == EscapeByte) begin
        if (at_limit) begin
          emit = 1'b1;
        end else begin
          esc_d = 1'b1;
        end
      end else if (is_prefix(byte_q)) begin
        emit = at_limit;
      end else begin
        emit = 1'b1;
        ok_d = classify(byte_q);
      end
      if (emit) begin
        done_d = 1'b1;
        esc_d  = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pos_q       <= '0;
      esc_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        pos_q  <= pos_d;
        esc_q  <= esc_d;
        done_q <= done_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q  <= in_i.insn_byte;
      start_q <= in_i.start_req;
    end
    if (advance && emit) begin
      ok_q    <= ok_d;
      count_q <= cur_pos;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.boostable      = ok_q;
  assign out_o.bytes_examined = count_q;

endmodule

`default_nettype wire
